@@ rtl/sard_pkg.sv @@
// package: shared constants, codes and types of the slot allocator
`default_nettype none
package sard_pkg;

   localparam int SLOT_COUNT   = 1024;
   localparam int SLOT_W       = $clog2(SLOT_COUNT);
   localparam int FIELD_SLOT_W = 10;
   localparam int INIT_W       = 11;
   localparam int COUNT_W      = (SLOT_W + 1 > INIT_W) ? SLOT_W + 1 : INIT_W;
   localparam int TIME_W       = 32;
   localparam int STATUS_W     = 2;
   localparam int CSR_INDEX_W  = 3;
   localparam int CSR_DATA_W   = 32;

   localparam logic [CSR_INDEX_W-1:0] CSR_FIRST_SCAN    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RESERVED_LAST = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_INITIAL_COUNT = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_EARLY_WINDOW  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_REUSE_AGE     = 3'd4;

   localparam logic [FIELD_SLOT_W-1:0] FIRST_SCAN_RESET    = 10'd1;
   localparam logic [FIELD_SLOT_W-1:0] RESERVED_LAST_RESET = 10'd9;
   localparam logic [INIT_W-1:0]       INITIAL_COUNT_RESET = 11'd10;
   localparam logic [TIME_W-1:0]       EARLY_WINDOW_RESET  = 32'd100;
   localparam logic [TIME_W-1:0]       REUSE_AGE_RESET     = 32'd500;

   localparam logic KIND_ALLOC = 1'b0;
   localparam logic KIND_FREE  = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NOT_USED = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_RESERVED = 2'd3;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ALLOC,
      ST_SCAN,
      ST_COMMIT,
      ST_FREE_RD,
      ST_FREE_CHK
   } state_type;

endpackage
`default_nettype wire

@@ rtl/sard_if.sv @@
// interfaces: request and response channels of the slot allocator
`default_nettype none
interface sard_req_if;
   logic                               valid;
   logic                               ready;
   logic                               kind;
   logic [sard_pkg::FIELD_SLOT_W-1:0]  slot_index;
   logic [sard_pkg::TIME_W-1:0]        now;

   modport source (output valid, output kind, output slot_index, output now, input ready);
   modport sink (input valid, input kind, input slot_index, input now, output ready);
endinterface

interface sard_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [sard_pkg::FIELD_SLOT_W-1:0]  granted_slot;
   logic [sard_pkg::STATUS_W-1:0]      status;

   modport source (output valid, output granted_slot, output status, input ready);
   modport sink (input valid, input granted_slot, input status, output ready);
endinterface
`default_nettype wire

@@ rtl/sard_ram.sv @@
// generic single-port-write, single-port-read ram with registered read
`default_nettype none
module sard_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

@@ rtl/slot_allocator_reuse_delay_core.sv @@
// top level: slot allocator with reuse delay, sequential scan over slot tables
//
//   channel   dir   handshake            payload
//   req_ch    in    valid/ready          kind, slot_index, now
//   rsp_ch    out   valid/ready          granted_slot, status
//   csr_*     in    write enable only    csr_index, csr_write_data
//
// allocate: scans from first_scan_slot up to high_water, one slot read per
//   cycle from the single read port of the slot tables; a full table skips the scan
// free: table read, then check and write
// after reset a clearing pass over all SLOT_COUNT entries zeroes both tables; no request meanwhile
// a finished response waits in an output register; the next transaction is taken
//   meanwhile and holds in its final step until the response register is free
`default_nettype none
module slot_allocator_reuse_delay_core (
   input  wire logic                               clock,
   input  wire logic                               reset,
   sard_req_if.sink                                req_ch,
   sard_rsp_if.source                              rsp_ch,
   input  wire logic                               csr_write_enable,
   input  wire logic [sard_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [sard_pkg::CSR_DATA_W-1:0]    csr_write_data
);

   localparam int SW = sard_pkg::SLOT_W;
   localparam int CW = sard_pkg::COUNT_W;
   localparam int FW = sard_pkg::FIELD_SLOT_W;
   localparam int TW = sard_pkg::TIME_W;

   sard_pkg::state_type state_ff, state_in;

   logic [FW-1:0] fsc_ff, fsc_in;
   logic [FW-1:0] resv_ff, resv_in;
   logic [sard_pkg::INIT_W-1:0] init_ff, init_in;
   logic [TW-1:0] early_ff, early_in;
   logic [TW-1:0] age_ff, age_in;
   logic [CW-1:0] hw_ff, hw_in;

   logic [SW-1:0] clr_ff, clr_in;
   logic [FW-1:0] slot_ff, slot_in;
   logic [TW-1:0] now_ff, now_in;
   logic          quick_ff, quick_in;
   logic [CW-1:0] addr_ff, addr_in;
   logic          rd_vld_ff, rd_vld_in;
   logic [SW-1:0] rd_idx_ff, rd_idx_in;
   logic [SW-1:0] pick_ff, pick_in;
   logic          found_ff, found_in;

   logic                              rsp_valid_ff, rsp_valid_in;
   logic [FW-1:0]                     rsp_slot_ff, rsp_slot_in;
   logic [sard_pkg::STATUS_W-1:0]     rsp_status_ff, rsp_status_in;

   logic          busy_we, busy_wdata, busy_rd;
   logic [SW-1:0] busy_waddr;
   logic          time_we;
   logic [SW-1:0] time_waddr;
   logic [TW-1:0] time_wdata, time_rd;
   logic          rd_en;
   logic [SW-1:0] rd_addr;

   logic          out_free;
   logic          issue;
   logic          free_hit;
   logic          aged;
   logic [TW-1:0] age_diff;
   logic          slot_in_range;
   logic [SW-1:0] grant;

   sard_ram #(.WIDTH(1), .DEPTH(sard_pkg::SLOT_COUNT)) u_busy_ram (
      .clock   (clock),
      .wr_en   (busy_we),
      .wr_addr (busy_waddr),
      .wr_data (busy_wdata),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (busy_rd)
   );

   sard_ram #(.WIDTH(TW), .DEPTH(sard_pkg::SLOT_COUNT)) u_time_ram (
      .clock   (clock),
      .wr_en   (time_we),
      .wr_addr (time_waddr),
      .wr_data (time_wdata),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (time_rd)
   );

   assign out_free      = !rsp_valid_ff || rsp_ch.ready;
   assign issue         = (state_ff == sard_pkg::ST_SCAN) && (addr_ff < hw_ff);
   assign free_hit      = rd_vld_ff && !busy_rd;
   assign age_diff      = now_ff - time_rd;
   assign aged          = age_diff > age_ff;
   assign slot_in_range = 32'(slot_ff) < 32'(sard_pkg::SLOT_COUNT);
   assign grant         = found_ff ? pick_ff : hw_ff[SW-1:0];

   assign req_ch.ready        = (state_ff == sard_pkg::ST_IDLE);
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.granted_slot = rsp_slot_ff;
   assign rsp_ch.status       = rsp_status_ff;

   always_comb begin
      state_in      = state_ff;
      fsc_in        = fsc_ff;
      resv_in       = resv_ff;
      init_in       = init_ff;
      early_in      = early_ff;
      age_in        = age_ff;
      hw_in         = hw_ff;
      clr_in        = clr_ff;
      slot_in       = slot_ff;
      now_in        = now_ff;
      quick_in      = quick_ff;
      addr_in       = addr_ff;
      rd_vld_in     = issue;
      rd_idx_in     = addr_ff[SW-1:0];
      pick_in       = pick_ff;
      found_in      = found_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_slot_in   = rsp_slot_ff;
      rsp_status_in = rsp_status_ff;
      busy_we       = 1'b0;
      busy_waddr    = clr_ff;
      busy_wdata    = 1'b0;
      time_we       = 1'b0;
      time_waddr    = clr_ff;
      time_wdata    = '0;
      rd_en         = issue;
      rd_addr       = addr_ff[SW-1:0];

      unique case (state_ff)
         sard_pkg::ST_CLEAR: begin
            busy_we = 1'b1;
            time_we = 1'b1;
            clr_in  = clr_ff + SW'(1);
            if (clr_ff == SW'(sard_pkg::SLOT_COUNT - 1)) begin
               state_in = sard_pkg::ST_IDLE;
            end
         end
         sard_pkg::ST_IDLE: begin
            if (req_ch.valid) begin
               slot_in  = req_ch.slot_index;
               now_in   = req_ch.now;
               state_in = (req_ch.kind == sard_pkg::KIND_FREE) ? sard_pkg::ST_FREE_RD
                                                               : sard_pkg::ST_ALLOC;
            end
         end
         sard_pkg::ST_ALLOC: begin
            quick_in = now_ff < early_ff;
            found_in = 1'b0;
            addr_in  = CW'(fsc_ff);
            if (hw_ff >= CW'(sard_pkg::SLOT_COUNT)) begin
               if (out_free) begin
                  rsp_valid_in  = 1'b1;
                  rsp_slot_in   = '0;
                  rsp_status_in = sard_pkg::STATUS_FULL;
                  state_in      = sard_pkg::ST_IDLE;
               end
            end else begin
               state_in = sard_pkg::ST_SCAN;
            end
         end
         sard_pkg::ST_SCAN: begin
            if (issue) begin
               addr_in = addr_ff + CW'(1);
            end
            if (free_hit && (quick_ff || aged)) begin
               pick_in  = rd_idx_ff;
               found_in = 1'b1;
               state_in = sard_pkg::ST_COMMIT;
            end else begin
               if (free_hit && !found_ff) begin
                  pick_in  = rd_idx_ff;
                  found_in = 1'b1;
               end
               if (!rd_vld_ff && !issue) begin
                  state_in = sard_pkg::ST_COMMIT;
               end
            end
         end
         sard_pkg::ST_COMMIT: begin
            if (out_free) begin
               busy_we       = 1'b1;
               busy_waddr    = grant;
               busy_wdata    = 1'b1;
               rsp_valid_in  = 1'b1;
               rsp_slot_in   = FW'(grant);
               rsp_status_in = sard_pkg::STATUS_OK;
               state_in      = sard_pkg::ST_IDLE;
               if (!found_ff) begin
                  hw_in = hw_ff + CW'(1);
               end
            end
         end
         sard_pkg::ST_FREE_RD: begin
            rd_en    = 1'b1;
            rd_addr  = SW'(slot_ff);
            state_in = sard_pkg::ST_FREE_CHK;
         end
         sard_pkg::ST_FREE_CHK: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_slot_in  = '0;
               state_in     = sard_pkg::ST_IDLE;
               priority if (!slot_in_range || !busy_rd) begin
                  rsp_status_in = sard_pkg::STATUS_NOT_USED;
               end else if (slot_ff <= resv_ff) begin
                  rsp_status_in = sard_pkg::STATUS_RESERVED;
               end else begin
                  rsp_status_in = sard_pkg::STATUS_OK;
                  busy_we       = 1'b1;
                  busy_waddr    = SW'(slot_ff);
                  busy_wdata    = 1'b0;
                  time_we       = 1'b1;
                  time_waddr    = SW'(slot_ff);
                  time_wdata    = now_ff;
               end
            end
         end
         default: begin
            state_in = sard_pkg::ST_IDLE;
         end
      endcase

      if (csr_write_enable) begin
         unique case (csr_index)
            sard_pkg::CSR_FIRST_SCAN:    fsc_in   = csr_write_data[FW-1:0];
            sard_pkg::CSR_RESERVED_LAST: resv_in  = csr_write_data[FW-1:0];
            sard_pkg::CSR_INITIAL_COUNT: begin
               init_in = csr_write_data[sard_pkg::INIT_W-1:0];
               hw_in   = CW'(csr_write_data[sard_pkg::INIT_W-1:0]);
            end
            sard_pkg::CSR_EARLY_WINDOW:  early_in = csr_write_data[TW-1:0];
            sard_pkg::CSR_REUSE_AGE:     age_in   = csr_write_data[TW-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sard_pkg::ST_CLEAR;
         fsc_ff       <= sard_pkg::FIRST_SCAN_RESET;
         resv_ff      <= sard_pkg::RESERVED_LAST_RESET;
         init_ff      <= sard_pkg::INITIAL_COUNT_RESET;
         early_ff     <= sard_pkg::EARLY_WINDOW_RESET;
         age_ff       <= sard_pkg::REUSE_AGE_RESET;
         hw_ff        <= CW'(sard_pkg::INITIAL_COUNT_RESET);
         clr_ff       <= '0;
         rd_vld_ff    <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fsc_ff       <= fsc_in;
         resv_ff      <= resv_in;
         init_ff      <= init_in;
         early_ff     <= early_in;
         age_ff       <= age_in;
         hw_ff        <= hw_in;
         clr_ff       <= clr_in;
         rd_vld_ff    <= rd_vld_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff       <= slot_in;
      now_ff        <= now_in;
      quick_ff      <= quick_in;
      addr_ff       <= addr_in;
      rd_idx_ff     <= rd_idx_in;
      pick_ff       <= pick_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_status_ff <= rsp_status_in;
   end

   // high water moves only by a count write or an append
   assert property (@(posedge clock) disable iff (reset)
      (!(csr_write_enable && csr_index == sard_pkg::CSR_INITIAL_COUNT)
       && state_ff != sard_pkg::ST_COMMIT) |=> $stable(hw_ff))
      else $error("high water changed outside append or count write");

   // clearing pass ends after the last entry
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == sard_pkg::ST_CLEAR && clr_ff == SW'(sard_pkg::SLOT_COUNT - 1))
      |=> state_ff == sard_pkg::ST_IDLE)
      else $error("clearing pass did not end at last entry");

   // scan only looks at slots below high water
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == sard_pkg::ST_SCAN && rd_vld_ff) |-> (CW'(rd_idx_ff) < hw_ff))
      else $error("scan read beyond high water");

   // a committed allocation marks its slot busy together with the response
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == sard_pkg::ST_COMMIT && out_free)
      |=> rsp_valid_ff && rsp_status_ff == sard_pkg::STATUS_OK)
      else $error("allocation commit without ok response");

endmodule
`default_nettype wire

@@ tb/sv/testbench.sv @@
// testbench: random and directed checks of the slot allocator against a built-in predictor
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLOCK_PERIOD   = 10;
   localparam int LONG_HOLD      = 400;
   localparam int DRAIN_CYCLES   = 20;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int RANDOM_PHASES  = 8;

   typedef struct packed {
      logic                              kind;
      logic [sard_pkg::FIELD_SLOT_W-1:0] slot_index;
      logic [sard_pkg::TIME_W-1:0]       now;
   } slot_request_type;

   typedef struct packed {
      logic [sard_pkg::FIELD_SLOT_W-1:0] granted_slot;
      logic [sard_pkg::STATUS_W-1:0]     status;
   } slot_grant_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                             csr_write_enable = 1'b0;
   logic [sard_pkg::CSR_INDEX_W-1:0] csr_index        = '0;
   logic [sard_pkg::CSR_DATA_W-1:0]  csr_write_data   = '0;

   sard_req_if req_ch();
   sard_rsp_if rsp_ch();

   slot_allocator_reuse_delay_core i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_ch           (req_ch),
      .rsp_ch           (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // mirror of the slot tables and registers
   logic                              slot_busy_map [sard_pkg::SLOT_COUNT];
   logic [sard_pkg::TIME_W-1:0]       freed_stamp   [sard_pkg::SLOT_COUNT];
   logic [sard_pkg::COUNT_W-1:0]      high_water;
   logic [sard_pkg::FIELD_SLOT_W-1:0] scan_start;
   logic [sard_pkg::FIELD_SLOT_W-1:0] reserved_top;
   logic [sard_pkg::INIT_W-1:0]       count_preset;
   logic [sard_pkg::TIME_W-1:0]       early_window;
   logic [sard_pkg::TIME_W-1:0]       reuse_age;

   slot_request_type queued_requests [$];
   slot_grant_type   pending_grants  [$];
   int  mismatch_count = 0;
   bit  steady_traffic = 1'b0;
   int  send_gap       = 0;
   int  stall_left     = 0;
   int  hold_left      = 0;
   int  grants_seen    = 0;
   int  quiet_cycles   = 0;

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   function automatic int pick_gap(bit steady);
      int r;
      r = $urandom_range(0, 99);
      if (steady || r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 80);
   endfunction

   function automatic slot_grant_type grant_for(slot_request_type req);
      slot_grant_type              grant;
      int                          pick;
      bit                          found;
      bit                          quick;
      logic [sard_pkg::TIME_W-1:0] age;
      grant.granted_slot = '0;
      grant.status       = sard_pkg::STATUS_OK;
      if (req.kind == sard_pkg::KIND_ALLOC) begin
         if (high_water >= sard_pkg::SLOT_COUNT) begin
            grant.status = sard_pkg::STATUS_FULL;
         end else begin
            quick = req.now < early_window;
            found = 1'b0;
            pick  = 0;
            for (int i = int'(scan_start); i < int'(high_water); i++) begin
               if (!slot_busy_map[i]) begin
                  age = req.now - freed_stamp[i];
                  if (quick || age > reuse_age) begin
                     pick  = i;
                     found = 1'b1;
                     break;
                  end
                  if (!found) begin
                     pick  = i;
                     found = 1'b1;
                  end
               end
            end
            if (!found) begin
               pick       = int'(high_water);
               high_water = high_water + 1'b1;
            end
            slot_busy_map[pick] = 1'b1;
            grant.granted_slot  = sard_pkg::FIELD_SLOT_W'(pick);
         end
      end else if (!slot_busy_map[req.slot_index]) begin
         grant.status = sard_pkg::STATUS_NOT_USED;
      end else if (req.slot_index <= reserved_top) begin
         grant.status = sard_pkg::STATUS_RESERVED;
      end else begin
         slot_busy_map[req.slot_index] = 1'b0;
         freed_stamp[req.slot_index]   = req.now;
      end
      return grant;
   endfunction

   task automatic enqueue(input logic kind, input int slot,
                          input logic [sard_pkg::TIME_W-1:0] now);
      slot_request_type req;
      req.kind        = kind;
      req.slot_index  = sard_pkg::FIELD_SLOT_W'(slot);
      req.now         = now;
      queued_requests = {queued_requests, req};
   endtask

   task automatic write_csr(input logic [sard_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [sard_pkg::CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         sard_pkg::CSR_FIRST_SCAN:    scan_start   = data[sard_pkg::FIELD_SLOT_W-1:0];
         sard_pkg::CSR_RESERVED_LAST: reserved_top = data[sard_pkg::FIELD_SLOT_W-1:0];
         sard_pkg::CSR_INITIAL_COUNT: begin
            count_preset = data[sard_pkg::INIT_W-1:0];
            high_water   = sard_pkg::COUNT_W'(data[sard_pkg::INIT_W-1:0]);
         end
         sard_pkg::CSR_EARLY_WINDOW:  early_window = data;
         sard_pkg::CSR_REUSE_AGE:     reuse_age    = data;
         default: ;
      endcase
   endtask

   task automatic wait_for_grants_drained();
      while (queued_requests.size() != 0 || pending_grants.size() != 0) @(posedge clock);
   endtask

   // request driver
   always @(posedge clock) begin
      slot_grant_type predicted;
      if (reset) begin
         req_ch.valid <= 1'b0;
         send_gap     = 0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            predicted      = grant_for(queued_requests.pop_front());
            pending_grants = {pending_grants, predicted};
            send_gap       = pick_gap(steady_traffic);
         end
         if (!(req_ch.valid && !req_ch.ready)) begin
            if (send_gap > 0 || queued_requests.size() == 0) begin
               if (send_gap > 0) send_gap--;
               req_ch.valid <= 1'b0;
            end else begin
               req_ch.valid      <= 1'b1;
               req_ch.kind       <= queued_requests[0].kind;
               req_ch.slot_index <= queued_requests[0].slot_index;
               req_ch.now        <= queued_requests[0].now;
            end
         end
      end
   end

   // response monitor and ready pacing
   always @(posedge clock) begin
      slot_grant_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            grants_seen++;
            if (pending_grants.size() == 0) begin
               $error("unexpected transaction: granted_slot %0d, status %0d",
                      rsp_ch.granted_slot, rsp_ch.status);
               mismatch_count++;
            end else begin
               want = pending_grants.pop_front();
               if (rsp_ch.granted_slot !== want.granted_slot) begin
                  $error("granted_slot: expected %0d, actual %0d",
                         want.granted_slot, rsp_ch.granted_slot);
                  mismatch_count++;
               end
               if (rsp_ch.status !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, rsp_ch.status);
                  mismatch_count++;
               end
            end
            if (grants_seen == 120 || grants_seen == 350) hold_left = LONG_HOLD;
            else stall_left = pick_gap(steady_traffic);
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   initial begin
      int                              items;
      int                              r;
      int                              pick;
      logic [sard_pkg::TIME_W-1:0]     clock_ms;
      logic [sard_pkg::CSR_DATA_W-1:0] fs, rl, ic, ew, ra;
      int                              held_slots [$];

      req_ch.valid      = 1'b0;
      req_ch.kind       = sard_pkg::KIND_ALLOC;
      req_ch.slot_index = '0;
      req_ch.now        = '0;
      rsp_ch.ready      = 1'b0;
      for (int i = 0; i < sard_pkg::SLOT_COUNT; i++) begin
         slot_busy_map[i] = 1'b0;
         freed_stamp[i]   = '0;
      end
      scan_start   = sard_pkg::FIRST_SCAN_RESET;
      reserved_top = sard_pkg::RESERVED_LAST_RESET;
      count_preset = sard_pkg::INITIAL_COUNT_RESET;
      early_window = sard_pkg::EARLY_WINDOW_RESET;
      reuse_age    = sard_pkg::REUSE_AGE_RESET;
      high_water   = sard_pkg::COUNT_W'(sard_pkg::INITIAL_COUNT_RESET);

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset settings: reserved checks, early window, aged reuse, time wrap
      enqueue(sard_pkg::KIND_FREE, 0, 0);
      enqueue(sard_pkg::KIND_ALLOC, 1023, 0);
      enqueue(sard_pkg::KIND_FREE, 1, 5);
      enqueue(sard_pkg::KIND_FREE, 2, 5);
      enqueue(sard_pkg::KIND_FREE, 1023, 5);
      for (int i = 0; i < 8; i++) enqueue(sard_pkg::KIND_ALLOC, 0, 10 + 10 * i);
      enqueue(sard_pkg::KIND_ALLOC, 0, 150);
      enqueue(sard_pkg::KIND_ALLOC, 0, 160);
      enqueue(sard_pkg::KIND_FREE, 10, 200);
      enqueue(sard_pkg::KIND_FREE, 11, 300);
      enqueue(sard_pkg::KIND_ALLOC, 0, 600);
      enqueue(sard_pkg::KIND_ALLOC, 0, 32'hFFFF_FFFF);
      enqueue(sard_pkg::KIND_FREE, 11, 32'hFFFF_FFF0);
      enqueue(sard_pkg::KIND_ALLOC, 0, 32'h0000_0100);
      wait_for_grants_drained();

      // zero count appends slot 0, then appends over a busy slot
      write_csr(sard_pkg::CSR_INITIAL_COUNT, 0);
      enqueue(sard_pkg::KIND_ALLOC, 0, 1000);
      enqueue(sard_pkg::KIND_ALLOC, 0, 1001);
      wait_for_grants_drained();

      // full table
      write_csr(sard_pkg::CSR_INITIAL_COUNT, sard_pkg::SLOT_COUNT);
      enqueue(sard_pkg::KIND_ALLOC, 0, 1500);
      wait_for_grants_drained();
      write_csr(sard_pkg::CSR_FIRST_SCAN, 1023);
      write_csr(sard_pkg::CSR_INITIAL_COUNT, sard_pkg::SLOT_COUNT - 1);
      enqueue(sard_pkg::KIND_ALLOC, 0, 1600);
      enqueue(sard_pkg::KIND_ALLOC, 0, 1700);
      enqueue(sard_pkg::KIND_FREE, 1023, 2000);
      wait_for_grants_drained();

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: begin fs = 1; rl = 0; ic = 1; ew = 0; ra = 0; items = 70; end
            1: begin fs = 5; rl = 20; ic = 30; ew = 1000; ra = 300; items = 80; end
            2: begin
               fs = 1023; rl = 1023; ic = 1000;
               ew = 32'hFFFF_FFFF; ra = 32'hFFFF_FFFF; items = 40;
            end
            3: begin
               fs = 1; rl = 9; ic = 1000; ew = 0; ra = $urandom_range(0, 2000); items = 30;
            end
            default: begin
               fs = $urandom_range(1, 40);
               rl = $urandom_range(0, 40);
               ic = $urandom_range(1, 64);
               ew = $urandom();
               ra = $urandom_range(0, 2000);
               items = 83;
            end
         endcase
         write_csr(sard_pkg::CSR_FIRST_SCAN, fs);
         write_csr(sard_pkg::CSR_RESERVED_LAST, rl);
         write_csr(sard_pkg::CSR_INITIAL_COUNT, ic);
         write_csr(sard_pkg::CSR_EARLY_WINDOW, ew);
         write_csr(sard_pkg::CSR_REUSE_AGE, ra);
         steady_traffic = (phase % 3 == 2);
         clock_ms = ($urandom_range(0, 2) == 0) ? '0 : sard_pkg::TIME_W'($urandom());

         for (int n = 0; n < items; n++) begin
            while (queued_requests.size() >= 3) @(posedge clock);
            if (phase == 1 && n == 40) wait_for_grants_drained();
            if ($urandom_range(0, 99) < 85) clock_ms += $urandom_range(0, 150);
            else clock_ms += $urandom_range(150, 3000);
            if ($urandom_range(0, 49) == 0) clock_ms = $urandom();
            r = $urandom_range(0, 99);
            held_slots.delete();
            if (r >= 45 && r < 85) begin
               for (int i = int'(reserved_top) + 1;
                    i < int'(high_water) && i < sard_pkg::SLOT_COUNT; i++)
                  if (slot_busy_map[i]) held_slots = {held_slots, i};
            end
            if (r < 45 || (r < 85 && held_slots.size() == 0)) begin
               enqueue(sard_pkg::KIND_ALLOC, $urandom_range(0, 1023), clock_ms);
            end else if (r < 85) begin
               pick = held_slots[$urandom_range(0, held_slots.size() - 1)];
               enqueue(sard_pkg::KIND_FREE, pick, clock_ms);
            end else if (r < 92) begin
               enqueue(sard_pkg::KIND_FREE, $urandom_range(0, 1023), clock_ms);
            end else begin
               enqueue($urandom_range(0, 1), $urandom_range(0, 1023), $urandom());
            end
         end
         wait_for_grants_drained();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_grants.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

@@ slot_allocator_reuse_delay_core.f @@
rtl/sard_pkg.sv
rtl/sard_if.sv
rtl/sard_ram.sv
rtl/slot_allocator_reuse_delay_core.sv
tb/sv/testbench.sv
